### rtl/mpq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mpq_pkg;

    // Default sizing
    localparam int DEFAULT_QUEUE_DEPTH   = 16;
    localparam int DEFAULT_PRIORITY_BITS = 16;

    // Fixed port widths
    localparam int VALUE_W   = 32;
    localparam int IN_PRIO_W = 16;
    localparam int COUNT_W   = 5;

    // Operation codes
    typedef enum logic {
        CMD_INSERT = 1'b0,
        CMD_REMOVE = 1'b1
    } t_cmd;

    // Controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_REPORT
    } t_state;

    // Controller to datapath commands
    typedef struct packed {
        logic load;   // capture the operands of an accepted transfer
        logic exec;   // apply the captured operation to the slots
    } t_dp_ctrl;

endpackage

`default_nettype wire

### rtl/mpq_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module mpq_datapath #(
    parameter int QUEUE_DEPTH   = mpq_pkg::DEFAULT_QUEUE_DEPTH,
    parameter int PRIORITY_BITS = mpq_pkg::DEFAULT_PRIORITY_BITS
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire mpq_pkg::t_dp_ctrl                    i_ctrl,
    input  wire logic                                 i_cmd,
    input  wire logic signed [mpq_pkg::VALUE_W-1:0]   i_item_value,
    input  wire logic        [mpq_pkg::IN_PRIO_W-1:0] i_item_priority,
    output logic signed      [mpq_pkg::VALUE_W-1:0]   o_head_value,
    output logic             [mpq_pkg::IN_PRIO_W-1:0] o_head_priority,
    output logic                                      o_queue_empty,
    output logic             [mpq_pkg::COUNT_W-1:0]   o_entry_count,
    output logic                                      o_insert_dropped
);
    import mpq_pkg::*;

    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int PB = PRIORITY_BITS;

    // Captured operands
    t_cmd                    r_cmd;
    logic signed [VALUE_W-1:0] r_value;
    logic [PB-1:0]           r_prio;

    // Sorted slots, head at index 0
    logic signed [VALUE_W-1:0] r_slot_value [QUEUE_DEPTH];
    logic [PB-1:0]           r_slot_prio  [QUEUE_DEPTH];
    logic [CW-1:0]           r_occ;
    logic [CW-1:0]           n_occ;
    logic                    r_dropped;
    logic                    n_dropped;

    logic                    full;
    logic                    empty;
    logic                    do_insert;
    logic                    do_remove;
    logic [QUEUE_DEPTH-1:0]  ge;       // slot holds an entry at or above the new priority
    logic [QUEUE_DEPTH-1:0]  prev_ge;  // same flag one slot toward the head

    // Operand capture on an accepted transfer
    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_cmd   <= t_cmd'(i_cmd);
            r_value <= i_item_value;
            r_prio  <= PB'(32'(i_item_priority));
        end
    end

    assign full      = (r_occ == CW'(QUEUE_DEPTH));
    assign empty     = (r_occ == '0);
    assign do_insert = i_ctrl.exec && (r_cmd == CMD_INSERT) && !full;
    assign do_remove = i_ctrl.exec && (r_cmd == CMD_REMOVE) && !empty;

    // Per-slot priority compare; sorted order makes ge a head-side prefix
    for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cmp
        assign ge[g] = (CW'(g) < r_occ) && (r_slot_prio[g] >= r_prio);
        if (g == 0) begin : g_head
            assign prev_ge[g] = 1'b1;
        end else begin : g_body
            assign prev_ge[g] = ge[g-1];
        end
    end

    // Compare-and-shift slot update
    for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_slot
        always_ff @(posedge i_clk) begin
            if (do_insert && !ge[g]) begin
                if (prev_ge[g]) begin
                    r_slot_value[g] <= r_value;
                    r_slot_prio[g]  <= r_prio;
                end else if (g > 0) begin
                    r_slot_value[g] <= r_slot_value[(g > 0) ? g - 1 : 0];
                    r_slot_prio[g]  <= r_slot_prio[(g > 0) ? g - 1 : 0];
                end
            end else if (do_remove && (g < QUEUE_DEPTH - 1)) begin
                r_slot_value[g] <= r_slot_value[(g < QUEUE_DEPTH - 1) ? g + 1 : g];
                r_slot_prio[g]  <= r_slot_prio[(g < QUEUE_DEPTH - 1) ? g + 1 : g];
            end
        end
    end

    // Occupancy and drop flag
    always_comb begin
        n_occ     = r_occ;
        n_dropped = r_dropped;
        if (i_ctrl.exec) begin
            n_dropped = (r_cmd == CMD_INSERT) && full;
            if (do_insert) begin
                n_occ = r_occ + CW'(1);
            end else if (do_remove) begin
                n_occ = r_occ - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ     <= '0;
            r_dropped <= 1'b0;
        end else begin
            r_occ     <= n_occ;
            r_dropped <= n_dropped;
        end
    end

    // Result fields, read while the controller reports
    assign o_queue_empty    = empty;
    assign o_head_value     = empty ? '0 : r_slot_value[0];
    assign o_head_priority  = empty ? '0 : IN_PRIO_W'(32'(r_slot_prio[0]));
    assign o_entry_count    = COUNT_W'(32'(r_occ));
    assign o_insert_dropped = r_dropped;

    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_occ <= CW'(QUEUE_DEPTH))
        else $error("occupancy above queue depth");

    a_remove_dec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        do_remove |=> r_occ == $past(r_occ) - CW'(1))
        else $error("remove did not shrink occupancy");

    a_drop_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctrl.exec && r_cmd == CMD_INSERT && full) |=>
            (r_dropped && r_occ == $past(r_occ)))
        else $error("dropped insert changed the queue");

    a_head_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_occ >= CW'(2)) |-> (r_slot_prio[0] >= r_slot_prio[1]))
        else $error("head slot out of priority order");

endmodule

`default_nettype wire

### rtl/mpq_controller.sv
`timescale 1ns / 1ps
`default_nettype none

module mpq_controller (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_start,
    output logic          o_busy,
    output logic          o_valid,
    output mpq_pkg::t_dp_ctrl o_ctrl
);
    import mpq_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   accept;

    assign accept = i_start && !o_busy;

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:   n_state = accept ? ST_EXEC : ST_IDLE;
            ST_EXEC:   n_state = ST_REPORT;
            ST_REPORT: n_state = accept ? ST_EXEC : ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Outputs; a new transfer may be taken while the last result is shown
    always_comb begin
        o_busy      = 1'b0;
        o_valid     = 1'b0;
        o_ctrl.exec = 1'b0;
        case (r_state)
            ST_IDLE:   ;
            ST_EXEC: begin
                o_busy      = 1'b1;
                o_ctrl.exec = 1'b1;
            end
            ST_REPORT: o_valid = 1'b1;
            default:   o_busy  = 1'b1;
        endcase
        o_ctrl.load = i_start && !o_busy;
    end

    a_exec_report: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ctrl.exec |=> o_valid)
        else $error("update not followed by result");

    a_valid_after_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(o_ctrl.exec))
        else $error("result without an update");

    a_load_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ctrl.load |=> o_ctrl.exec)
        else $error("accepted transfer not executed");

endmodule

`default_nettype wire

### rtl/max_priority_queue_top.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Ports                                          Handshake
// command   i_cmd, i_item_value, i_item_priority           start high, busy low
// result    o_head_value, o_head_priority, o_queue_empty,  o_valid, one cycle
//           o_entry_count, o_insert_dropped
//
// Each command first applies the insert or remove across all slots in
// parallel, then shows the result. busy is high only while the slots are
// updated, so the next command can be taken while a result is on the ports.
// Reset (synchronous, active low) empties the queue; slot contents stay
// undefined until written. The receiver cannot stall the result.

module max_priority_queue_top #(
    parameter int QUEUE_DEPTH   = mpq_pkg::DEFAULT_QUEUE_DEPTH,
    parameter int PRIORITY_BITS = mpq_pkg::DEFAULT_PRIORITY_BITS
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 start,
    output logic                                      busy,
    input  wire logic                                 i_cmd,
    input  wire logic signed [mpq_pkg::VALUE_W-1:0]   i_item_value,
    input  wire logic        [mpq_pkg::IN_PRIO_W-1:0] i_item_priority,
    output logic                                      o_valid,
    output logic signed      [mpq_pkg::VALUE_W-1:0]   o_head_value,
    output logic             [mpq_pkg::IN_PRIO_W-1:0] o_head_priority,
    output logic                                      o_queue_empty,
    output logic             [mpq_pkg::COUNT_W-1:0]   o_entry_count,
    output logic                                      o_insert_dropped
);
    import mpq_pkg::*;

    t_dp_ctrl ctrl;

    mpq_controller u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .o_busy  (busy),
        .o_valid (o_valid),
        .o_ctrl  (ctrl)
    );

    mpq_datapath #(
        .QUEUE_DEPTH   (QUEUE_DEPTH),
        .PRIORITY_BITS (PRIORITY_BITS)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_ctrl           (ctrl),
        .i_cmd            (i_cmd),
        .i_item_value     (i_item_value),
        .i_item_priority  (i_item_priority),
        .o_head_value     (o_head_value),
        .o_head_priority  (o_head_priority),
        .o_queue_empty    (o_queue_empty),
        .o_entry_count    (o_entry_count),
        .o_insert_dropped (o_insert_dropped)
    );

endmodule

`default_nettype wire
